@@ rtl/core/atmg_pkg.sv @@
`timescale 1ns / 1ps

package atmg_pkg;

  // Payload width of every request and result field
  localparam int DATA_W = 32;

  // Internal fixed-point formats: angle in degrees with 24 fraction bits,
  // rotation vector with 30 fraction bits
  localparam int ANG_FRAC = 24;
  localparam int VEC_FRAC = 30;

  // Width of the angle residue during range reduction
  localparam int RED_W = 36;
  // Width of the CORDIC angle accumulator and of the vector components
  localparam int Z_W = 34;
  localparam int V_W = 34;

  // Limit of the CORDIC gain, 30 fraction bits
  localparam logic signed [V_W-1:0] GAIN_K = 34'sd652032874;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam int ATAN_LEN = 24;
  localparam logic [29:0] ATAN_DEG [ATAN_LEN] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115
  };

  // Transform kinds
  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_REFLECT   = 2'd3
  } atmg_mode_e;

  // Control and pass-through data that travels with each request
  typedef struct packed {
    logic                     vld;
    atmg_mode_e               mode;
    logic                     neg;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } atmg_tag_t;

  // Top two rows of the homogeneous matrix
  typedef struct packed {
    logic signed [DATA_W-1:0] r0c0;
    logic signed [DATA_W-1:0] r0c1;
    logic signed [DATA_W-1:0] r0c2;
    logic signed [DATA_W-1:0] r1c0;
    logic signed [DATA_W-1:0] r1c1;
    logic signed [DATA_W-1:0] r1c2;
  } atmg_mat_t;

endpackage

@@ rtl/core/affine_transform_matrix_gen.sv @@
`timescale 1ns / 1ps

// 2D homogeneous transform matrix generator.
// Request channel: in_valid_i / in_stall_o with mode_i, param_a_i and
// param_b_i (Q16.16 by default). Result channel: out_valid_o / out_stall_i
// with the six entries of the top two matrix rows; the third row is 0 0 1.
// A request or result moves at a clock edge with valid high and stall low.
// Throughput: one request per cycle while no full skid entry freezes the
// pipeline. From acceptance a request passes the input register, the row
// of modulo-360 reduction cells, the fold register, the row of CORDIC
// cells, and the rounding and output registers on its way to out_valid_o.
// The angle is reduced modulo 360 degrees (twice the angle for reflection),
// folded to [-90, 90] and rotated by the CORDIC cells.
// When the receiver stalls, the result holds on the outputs and one more
// result goes into a skid entry; in_stall_o is raised only while that entry
// is full, which freezes the whole pipeline. in_stall_o is a register.
// Reset clears all valid bits; no result is pending after reset.
module affine_transform_matrix_gen #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] param_a_i,
  input  logic signed [31:0] param_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] row0_col0_o,
  output logic signed [31:0] row0_col1_o,
  output logic signed [31:0] row0_col2_o,
  output logic signed [31:0] row1_col0_o,
  output logic signed [31:0] row1_col1_o,
  output logic signed [31:0] row1_col2_o
);

  localparam int RW = atmg_pkg::RED_W;
  localparam int ZW = atmg_pkg::Z_W;
  localparam int VW = atmg_pkg::V_W;
  localparam int ANG_SHIFT = atmg_pkg::ANG_FRAC - FRAC_BITS;

  // reduction constants in the input format
  localparam longint FULL_TURN = 64'sd360 <<< FRAC_BITS;
  localparam longint TWO_P32   = 64'sd1 <<< 32;
  localparam longint NEG_OFFS  = ((TWO_P32 + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
  localparam int     MOD_STEPS = $clog2((TWO_P32 + 2 * FULL_TURN - 1) / FULL_TURN);
  localparam logic [RW-1:0] DEG90_C  = RW'(64'sd90 <<< FRAC_BITS);
  localparam logic [RW-1:0] DEG180_C = RW'(64'sd180 <<< FRAC_BITS);
  localparam logic [RW-1:0] DEG270_C = RW'(64'sd270 <<< FRAC_BITS);
  localparam logic [RW-1:0] FULL_C   = RW'(FULL_TURN);
  localparam logic [RW-1:0] OFFS_C   = RW'(NEG_OFFS);

  atmg_pkg::atmg_tag_t  in_tag, fold_tag_d, fold_tag_q;
  atmg_pkg::atmg_tag_t  mod_tag [MOD_STEPS+1];
  logic [RW-1:0]        mod_r   [MOD_STEPS+1];
  atmg_pkg::atmg_tag_t  cor_tag [CORDIC_STEPS+1];
  logic signed [VW-1:0] cor_x   [CORDIC_STEPS+1];
  logic signed [VW-1:0] cor_y   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cor_z   [CORDIC_STEPS+1];
  atmg_pkg::atmg_tag_t  prep_tag_q;
  logic [33:0]          ang;
  logic [RW-1:0]        ang_w, r0_d, r0_q, r_red, r_fold;
  logic signed [ZW-1:0] z_d, z_q;
  logic                 adv;
  atmg_pkg::atmg_mat_t  mat;

  assign in_stall_o = !adv;

  // input stage: pick the angle (doubled for reflection), lift negatives
  always_comb begin
    in_tag      = '0;
    in_tag.vld  = in_valid_i && adv;
    in_tag.mode = atmg_pkg::atmg_mode_e'(mode_i);
    in_tag.a    = param_a_i;
    in_tag.b    = param_b_i;
    if (in_tag.mode == atmg_pkg::MODE_REFLECT) begin
      ang = {param_a_i[31], param_a_i, 1'b0};
    end else begin
      ang = {{2{param_a_i[31]}}, param_a_i};
    end
    ang_w = {{(RW-34){ang[33]}}, ang};
    r0_d  = ang[33] ? (ang_w + OFFS_C) : ang_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_tag_q <= '0;
    end else if (adv) begin
      prep_tag_q <= in_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r0_q <= r0_d;
    end
  end

  assign mod_tag[0] = prep_tag_q;
  assign mod_r[0]   = r0_q;

  // modulo-360 cells, largest multiple first
  for (genvar g = 0; g < MOD_STEPS; g++) begin : g_mod
    atmg_mod_cell #(
      .RW      (RW),
      .SUB_VAL (FULL_TURN <<< (MOD_STEPS - 1 - g))
    ) u_mod_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tag_i  (mod_tag[g]),
      .r_i    (mod_r[g]),
      .tag_o  (mod_tag[g+1]),
      .r_o    (mod_r[g+1])
    );
  end

  // fold [0, 360) into [-90, 90]; a half-turn fold negates sin and cos
  always_comb begin
    r_red          = mod_r[MOD_STEPS];
    fold_tag_d     = mod_tag[MOD_STEPS];
    fold_tag_d.neg = (r_red > DEG90_C) && (r_red < DEG270_C);
    if (r_red <= DEG90_C) begin
      r_fold = r_red;
    end else if (r_red < DEG270_C) begin
      r_fold = r_red - DEG180_C;
    end else begin
      r_fold = r_red - FULL_C;
    end
    z_d = ZW'($signed(r_fold) <<< ANG_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_tag_q <= '0;
    end else if (adv) begin
      fold_tag_q <= fold_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z_q <= z_d;
    end
  end

  assign cor_tag[0] = fold_tag_q;
  assign cor_x[0]   = atmg_pkg::GAIN_K;
  assign cor_y[0]   = '0;
  assign cor_z[0]   = z_q;

  // CORDIC cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    atmg_cordic_cell #(
      .SHIFT (g),
      .ATAN  (longint'(atmg_pkg::ATAN_DEG[g]))
    ) u_cordic_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tag_i  (cor_tag[g]),
      .x_i    (cor_x[g]),
      .y_i    (cor_y[g]),
      .z_i    (cor_z[g]),
      .tag_o  (cor_tag[g+1]),
      .x_o    (cor_x[g+1]),
      .y_o    (cor_y[g+1]),
      .z_o    (cor_z[g+1])
    );
  end

  atmg_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (cor_tag[CORDIC_STEPS]),
    .x_i         (cor_x[CORDIC_STEPS]),
    .y_i         (cor_y[CORDIC_STEPS]),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .mat_o       (mat)
  );

  assign row0_col0_o = mat.r0c0;
  assign row0_col1_o = mat.r0c1;
  assign row0_col2_o = mat.r0c2;
  assign row1_col0_o = mat.r1c0;
  assign row1_col1_o = mat.r1c1;
  assign row1_col2_o = mat.r1c2;

endmodule

@@ rtl/core/atmg_mod_cell.sv @@
`timescale 1ns / 1ps

// One restoring step of the modulo-360 reduction: subtract a fixed
// multiple of a full turn when the residue is at least that large.
module atmg_mod_cell #(
  parameter int     RW      = 36,
  parameter longint SUB_VAL = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  atmg_pkg::atmg_tag_t tag_i,
  input  logic [RW-1:0]       r_i,
  output atmg_pkg::atmg_tag_t tag_o,
  output logic [RW-1:0]       r_o
);

  localparam logic [RW-1:0] SUB_C = RW'(SUB_VAL);

  atmg_pkg::atmg_tag_t tag_q;
  logic [RW-1:0]       r_d, r_q;

  // compare and subtract
  always_comb begin
    r_d = (r_i >= SUB_C) ? (r_i - SUB_C) : r_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q <= r_d;
    end
  end

  assign tag_o = tag_q;
  assign r_o   = r_q;

endmodule

@@ rtl/core/atmg_cordic_cell.sv @@
`timescale 1ns / 1ps

// One CORDIC rotation step with a fixed shift and arctangent constant.
module atmg_cordic_cell #(
  parameter int     SHIFT = 0,
  parameter longint ATAN  = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  atmg_pkg::atmg_tag_t                   tag_i,
  input  logic signed [atmg_pkg::V_W-1:0]       x_i,
  input  logic signed [atmg_pkg::V_W-1:0]       y_i,
  input  logic signed [atmg_pkg::Z_W-1:0]       z_i,
  output atmg_pkg::atmg_tag_t                   tag_o,
  output logic signed [atmg_pkg::V_W-1:0]       x_o,
  output logic signed [atmg_pkg::V_W-1:0]       y_o,
  output logic signed [atmg_pkg::Z_W-1:0]       z_o
);

  localparam int ZW = atmg_pkg::Z_W;
  localparam int VW = atmg_pkg::V_W;
  localparam logic signed [ZW-1:0] ATAN_C = ZW'(ATAN);

  atmg_pkg::atmg_tag_t     tag_q;
  logic signed [VW-1:0]    dx, dy;
  logic signed [VW-1:0]    x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]    z_d, z_q;

  // rotate toward zero residual angle; zero counts as positive
  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!z_i[ZW-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN_C;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN_C;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign tag_o = tag_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

@@ rtl/core/atmg_out.sv @@
`timescale 1ns / 1ps

// Rounds the CORDIC vector, builds the matrix rows and holds the result
// in an output register with a skid entry behind it.
module atmg_out #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  atmg_pkg::atmg_tag_t             tag_i,
  input  logic signed [atmg_pkg::V_W-1:0] x_i,
  input  logic signed [atmg_pkg::V_W-1:0] y_i,
  input  logic                            out_stall_i,
  output logic                            adv_o,
  output logic                            out_valid_o,
  output atmg_pkg::atmg_mat_t             mat_o
);

  localparam int VW = atmg_pkg::V_W;
  localparam int DW = atmg_pkg::DATA_W;
  localparam int SH = atmg_pkg::VEC_FRAC - FRAC_BITS;
  localparam logic signed [VW-1:0] HALF = VW'(64'sd1 <<< (SH - 1));
  localparam logic signed [DW-1:0] ONE  = DW'(64'sd1 <<< FRAC_BITS);
  // entries in (-0.005, 0) are flushed: v > -ceil(5 * 2^F / 1000)
  localparam longint FLUSH_LIM = ((64'sd5 <<< FRAC_BITS) + 999) / 1000;
  localparam logic signed [DW-1:0] FLUSH_NEG = -DW'(FLUSH_LIM);

  atmg_pkg::atmg_tag_t  tag_q;
  logic signed [VW-1:0] xr, yr, xs, ys;
  logic signed [DW-1:0] c_d, s_d, c_q, s_q;
  logic signed [DW-1:0] neg_c, neg_s;
  atmg_pkg::atmg_mat_t  mat_d, out_q, skid_q;
  logic                 out_vld_q, skid_vld_q, take, adv;

  function automatic logic signed [DW-1:0] flush(input logic signed [DW-1:0] v);
    logic hit;
    hit = v[DW-1] && (v > FLUSH_NEG);
    return hit ? '0 : v;
  endfunction

  assign adv  = !skid_vld_q;
  assign take = out_vld_q && !out_stall_i;

  // round half up, with the fold negation merged into the add
  always_comb begin
    xr  = tag_i.neg ? (HALF - x_i) : (x_i + HALF);
    yr  = tag_i.neg ? (HALF - y_i) : (y_i + HALF);
    xs  = xr >>> SH;
    ys  = yr >>> SH;
    c_d = DW'(xs);
    s_d = DW'(ys);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q <= c_d;
      s_q <= s_d;
    end
  end

  // matrix assembly
  always_comb begin
    neg_c = -c_q;
    neg_s = -s_q;
    mat_d = '0;
    unique case (tag_q.mode)
      atmg_pkg::MODE_TRANSLATE: begin
        mat_d.r0c0 = ONE;
        mat_d.r0c2 = tag_q.a;
        mat_d.r1c1 = ONE;
        mat_d.r1c2 = tag_q.b;
      end
      atmg_pkg::MODE_SCALE: begin
        mat_d.r0c0 = tag_q.a;
        mat_d.r1c1 = tag_q.b;
      end
      atmg_pkg::MODE_ROTATE: begin
        mat_d.r0c0 = flush(c_q);
        mat_d.r0c1 = flush(neg_s);
        mat_d.r1c0 = flush(s_q);
        mat_d.r1c1 = flush(c_q);
      end
      atmg_pkg::MODE_REFLECT: begin
        mat_d.r0c0 = flush(c_q);
        mat_d.r0c1 = flush(s_q);
        mat_d.r1c0 = flush(s_q);
        mat_d.r1c1 = flush(neg_c);
      end
    endcase
  end

  // output register plus skid entry; the pipeline freezes while skid is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || take) begin
      out_vld_q <= tag_q.vld;
    end else if (tag_q.vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || take) begin
      out_q <= mat_d;
    end else if (tag_q.vld) begin
      skid_q <= mat_d;
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_vld_q;
  assign mat_o       = out_q;

endmodule

@@ rtl/core/atmg_chk.sv @@
`timescale 1ns / 1ps

// Port-level checks of the transform matrix generator.
module atmg_chk #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] row0_col0_o,
  input logic signed [31:0] row0_col1_o,
  input logic signed [31:0] row0_col2_o,
  input logic signed [31:0] row1_col0_o,
  input logic signed [31:0] row1_col1_o,
  input logic signed [31:0] row1_col2_o
);

  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< FRAC_BITS);

  // a stalled result stays valid
  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its entries
  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(row0_col0_o) && $stable(row0_col1_o)
      && $stable(row0_col2_o) && $stable(row1_col0_o) && $stable(row1_col1_o)
      && $stable(row1_col2_o))
    else $error("result changed while stalled");

  // request side stalls only after a stalled result with one more behind it
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("request stall without a stalled result");

  // skid entry full implies a result on the outputs
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stall with empty output");

  // only translation fills the last column, and then the rest is identity
  a_translate_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (row0_col2_o != 0 || row1_col2_o != 0) |->
      row0_col0_o == ONE && row1_col1_o == ONE && row0_col1_o == 0
      && row1_col0_o == 0)
    else $error("last column set outside translation");

endmodule

bind affine_transform_matrix_gen atmg_chk #(.FRAC_BITS(FRAC_BITS)) u_atmg_chk (.*);

@@ tb/atmg_matrix_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the matrix generator, predicts each matrix from
// the accepted request and compares it entry by entry with what comes out.
module atmg_matrix_checker #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] param_a_i,
  input  logic signed [31:0] param_b_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] row0_col0_i,
  input  logic signed [31:0] row0_col1_i,
  input  logic signed [31:0] row0_col2_i,
  input  logic signed [31:0] row1_col0_i,
  input  logic signed [31:0] row1_col1_i,
  input  logic signed [31:0] row1_col2_i,
  output int                 pending_o,
  output int                 errors_o
);

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_TBL [24] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934,  30029717,  15018523,  7509720,
    3754917,   1877466,   938734,    469367,
    234684,    117342,    58671,     29335,
    14668,     7334,      3667,      1833,
    917,       458,       229,       115
  };
  localparam longint CORDIC_GAIN = 652032874;

  string               entry_names [6] = '{"row0_col0", "row0_col1", "row0_col2",
                                           "row1_col0", "row1_col1", "row1_col2"};
  atmg_pkg::atmg_mat_t expected_mats [$];
  atmg_pkg::atmg_mat_t got_mat;
  atmg_pkg::atmg_mat_t want_mat;
  int                  fail_count = 0;

  assign errors_o = fail_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Trig entries just below zero are snapped to zero
  function automatic longint flush_tiny_neg(input longint v);
    if (v < 0 && v * 1000 > -(longint'(5) <<< FRAC_BITS)) return 0;
    return v;
  endfunction

  // cos and sin of an angle in degrees (input format), result in input format
  function automatic void cordic_sin_cos(input longint ang, output longint c,
                                         output longint s);
    longint full, r, z, x, y, dx, dy, deg90, deg180, half;
    bit     flip;
    int     sh;
    full   = longint'(360) <<< FRAC_BITS;
    deg90  = longint'(90) <<< 24;
    deg180 = longint'(180) <<< 24;
    sh     = 30 - FRAC_BITS;
    flip   = 1'b0;
    // reduce to [0, 360), then fold into [-90, 90]
    r = ang % full;
    if (r < 0) r += full;
    z = r <<< (24 - FRAC_BITS);
    if (z > deg180) z -= 2 * deg180;
    if (z > deg90) begin
      z -= deg180;
      flip = 1'b1;
    end else if (z < -deg90) begin
      z += deg180;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_TBL[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    half = longint'(1) <<< (sh - 1);
    c = (x + half) >>> sh;
    s = (y + half) >>> sh;
  endfunction

  function automatic atmg_pkg::atmg_mat_t predict_matrix(
      input atmg_pkg::atmg_mode_e mode,
      input logic signed [31:0]   a,
      input logic signed [31:0]   b);
    atmg_pkg::atmg_mat_t m;
    longint              one, c, s;
    one = longint'(1) <<< FRAC_BITS;
    m = '0;
    case (mode)
      atmg_pkg::MODE_TRANSLATE: begin
        m.r0c0 = 32'(one);
        m.r0c2 = a;
        m.r1c1 = 32'(one);
        m.r1c2 = b;
      end
      atmg_pkg::MODE_SCALE: begin
        m.r0c0 = a;
        m.r1c1 = b;
      end
      atmg_pkg::MODE_ROTATE: begin
        cordic_sin_cos(longint'(a), c, s);
        m.r0c0 = 32'(flush_tiny_neg(c));
        m.r0c1 = 32'(flush_tiny_neg(-s));
        m.r1c0 = 32'(flush_tiny_neg(s));
        m.r1c1 = 32'(flush_tiny_neg(c));
      end
      default: begin
        // reflection works on twice the angle
        cordic_sin_cos(2 * longint'(a), c, s);
        m.r0c0 = 32'(flush_tiny_neg(c));
        m.r0c1 = 32'(flush_tiny_neg(s));
        m.r1c0 = 32'(flush_tiny_neg(s));
        m.r1c1 = 32'(flush_tiny_neg(-c));
      end
    endcase
    return m;
  endfunction

  // Sample both channels on the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        expected_mats.push_back(predict_matrix(atmg_pkg::atmg_mode_e'(mode_i),
                                               param_a_i, param_b_i));
      if (out_valid_i && !out_stall_i) begin
        got_mat = {row0_col0_i, row0_col1_i, row0_col2_i,
                   row1_col0_i, row1_col1_i, row1_col2_i};
        if (expected_mats.size() == 0) begin
          report_mismatch("matrix came out with no request waiting");
        end else begin
          want_mat = expected_mats.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (got_mat[191 - 32 * k -: 32] !== want_mat[191 - 32 * k -: 32])
              report_mismatch($sformatf("%s got %0d, want %0d", entry_names[k],
                                        $signed(got_mat[191 - 32 * k -: 32]),
                                        $signed(want_mat[191 - 32 * k -: 32])));
          end
        end
      end
    end
    pending_o <= expected_mats.size();
  end

endmodule

@@ tb/affine_transform_matrix_gen_tb.sv @@
`timescale 1ns / 1ps

module affine_transform_matrix_gen_tb;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int RAND_PER_PHASE = 220;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  atmg_pkg::atmg_mode_e req_mode = atmg_pkg::MODE_TRANSLATE;
  logic signed [31:0]   req_a = '0;
  logic signed [31:0]   req_b = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   r0c0, r0c1, r0c2, r1c0, r1c1, r1c2;
  int                   pending;
  int                   errors;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;

  always #5 clk_i = ~clk_i;

  affine_transform_matrix_gen #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .mode_i     (req_mode),
    .param_a_i  (req_a),
    .param_b_i  (req_b),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .row0_col0_o(r0c0),
    .row0_col1_o(r0c1),
    .row0_col2_o(r0c2),
    .row1_col0_o(r1c0),
    .row1_col1_o(r1c1),
    .row1_col2_o(r1c2)
  );

  atmg_matrix_checker #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .mode_i     (req_mode),
    .param_a_i  (req_a),
    .param_b_i  (req_b),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .row0_col0_i(r0c0),
    .row0_col1_i(r0c1),
    .row0_col2_i(r0c2),
    .row1_col0_i(r1c0),
    .row1_col1_i(r1c1),
    .row1_col2_i(r1c2),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // Random receiver stalls
  always @(posedge clk_i)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Drive one request and hold it until the block takes it
  task automatic send_request(input atmg_pkg::atmg_mode_e mode,
                              input logic signed [31:0] a,
                              input logic signed [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      req_mode  <= atmg_pkg::atmg_mode_e'($urandom_range(3));
      req_a     <= $urandom;
      req_b     <= $urandom;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_mode <= mode;
    req_a    <= a;
    req_b    <= b;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Random request, biased toward angles near multiples of 45 degrees where
  // the small-negative flush and the quadrant folds happen
  task automatic send_random();
    atmg_pkg::atmg_mode_e mode;
    logic signed [31:0]   a;
    logic signed [31:0]   b;
    int                   k;
    mode = atmg_pkg::atmg_mode_e'($urandom_range(3));
    k = int'($urandom_range(32)) - 16;
    case ($urandom_range(9))
      0, 1, 2: a = $urandom;
      3, 4, 5: a = int'($urandom_range(1440 * ONE)) - 720 * ONE;
      6, 7, 8: a = k * 45 * ONE + int'($urandom_range(ONE)) - ONE / 2;
      default: begin
        case ($urandom_range(4))
          0: a = 32'sh8000_0000;
          1: a = 32'sh7fff_ffff;
          2: a = 0;
          3: a = -1;
          default: a = 1;
        endcase
      end
    endcase
    b = ($urandom_range(1)) ? $urandom : int'($urandom_range(8 * ONE)) - 4 * ONE;
    send_request(mode, a, b);
  endtask

  // Stimulus
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every mode, folds and the near-zero flush
    send_request(atmg_pkg::MODE_TRANSLATE, 32'sh8000_0000, 32'sh7fff_ffff);
    send_request(atmg_pkg::MODE_TRANSLATE, 0, -1);
    send_request(atmg_pkg::MODE_SCALE, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(atmg_pkg::MODE_SCALE, -ONE, 2 * ONE);
    send_request(atmg_pkg::MODE_ROTATE, 0, 32'sh5555_aaaa);
    send_request(atmg_pkg::MODE_ROTATE, 90 * ONE, 0);
    send_request(atmg_pkg::MODE_ROTATE, 180 * ONE, 0);
    send_request(atmg_pkg::MODE_ROTATE, 270 * ONE, 0);
    send_request(atmg_pkg::MODE_ROTATE, 360 * ONE, 0);
    send_request(atmg_pkg::MODE_ROTATE, -90 * ONE, 0);
    send_request(atmg_pkg::MODE_ROTATE, 45 * ONE, 0);
    send_request(atmg_pkg::MODE_ROTATE, 30 * ONE + ONE / 3, 0);
    send_request(atmg_pkg::MODE_ROTATE, 90 * ONE + ONE / 5, 0);   // cos just below zero
    send_request(atmg_pkg::MODE_ROTATE, -ONE / 5, 0);             // sin just below zero
    send_request(atmg_pkg::MODE_ROTATE, 32'sh7fff_ffff, 0);
    send_request(atmg_pkg::MODE_ROTATE, 32'sh8000_0000, 0);
    send_request(atmg_pkg::MODE_REFLECT, 0, 32'shffff_ffff);
    send_request(atmg_pkg::MODE_REFLECT, 45 * ONE, 0);
    send_request(atmg_pkg::MODE_REFLECT, 90 * ONE, 0);
    send_request(atmg_pkg::MODE_REFLECT, 135 * ONE, 0);
    send_request(atmg_pkg::MODE_REFLECT, 45 * ONE + ONE / 10, 0);
    send_request(atmg_pkg::MODE_REFLECT, 32'sh7fff_ffff, 0);
    send_request(atmg_pkg::MODE_REFLECT, 32'sh8000_0000, 0);
    send_request(atmg_pkg::MODE_REFLECT, -200 * ONE, 0);

    // random phases: no idling, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 56; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 56; end
        default: begin send_idle_pct = 20; stall_pct <= 20; end
      endcase
      repeat (RAND_PER_PHASE) send_random();
    end

    // drain
    in_valid  <= 1'b0;
    stall_pct <= 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
